// File: design/lssc_pkg.sv
// lssc_pkg: constants shared by the lyapunov safety stop check
// fixed-point formats, quadratic form coefficients, envelope limits, outcome codes
// no dependencies
package lssc_pkg;

	// input fraction bits and coefficient fraction bits
	localparam int FRAC_BITS = 12;
	localparam int COEF_FRAC = 20;

	// field and datapath widths
	localparam int IN_W    = 16;
	localparam int PROD_W  = 2 * IN_W;
	localparam int COEF_W  = 26;
	localparam int TERM_W  = PROD_W + COEF_W;
	localparam int ACC_W   = TERM_W + 2;
	localparam int POT_OUT_W = 24;
	localparam int N_TERMS = 10;

	// rounding shift from accumulator format down to q8.16
	localparam int ROUND_SH = 2 * FRAC_BITS + COEF_FRAC - 16;
	localparam int POT_W    = ACC_W - ROUND_SH;
	localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (ROUND_SH - 1);

	// envelope limits, scaled to integer compare form
	localparam int ENV_A_W = IN_W + 3;
	localparam int ENV_B_W = IN_W + 7;
	localparam logic signed [ENV_A_W-1:0] ENV_LOW  = -(ENV_A_W'(2) <<< FRAC_BITS);
	localparam logic signed [ENV_B_W-1:0] ENV_HIGH = ENV_B_W'(9) <<< FRAC_BITS;

	// matrix weights, off-diagonal entries already doubled
	// order: ee, pp, dede, dpdp, ep, ede, edp, pde, pdp, dedp
	localparam logic signed [COEF_W-1:0] COEF [N_TERMS] = '{
		26'sd26700557,
		26'sd3075705,
		26'sd6043428,
		26'sd212361,
		-26'sd240330,
		26'sd8994966,
		-26'sd42392,
		-26'sd230836,
		26'sd551368,
		-26'sd4652
	};

	// outcome codes
	localparam logic [1:0] OUTCOME_CONT   = 2'd0;
	localparam logic [1:0] OUTCOME_STABLE = 2'd1;
	localparam logic [1:0] OUTCOME_FAIL   = 2'd2;

	localparam logic [15:0] MAX_TIME_RST = 16'd20;

endpackage

// File: design/lyapunov_safety_stop_check_core.sv
// lyapunov_safety_stop_check_core: five-stage pipeline computing x'Px and the stop decision
// depends on lssc_pkg
//
// usage:
//   input channel (in_valid/in_ready) carries one plant state per transaction:
//   elevation, pitch, their rates (signed q3.12) and sim_time in ticks.
//   output channel (out_valid/out_ready) returns one result per transaction:
//   stop, outcome, stop_time and the saturated q8.16 potential.
//   cfg_we/cfg_wdata write max_time; write it only while the pipeline is empty.
// pipeline and throughput:
//   an accepted transaction passes through the stage 1 to stage 5 registers in order
//   and is presented on the output from stage 5 until the receiver takes it.
//   one transaction per cycle is sustained while out_ready is high; the stages are
//   products, coefficient multiplies, partial sums, final sum, and the rounding/classify output register.
// reset:
//   all stage valid bits clear and max_time returns to 20.
// stall:
//   each stage holds while it is full and the next one cannot take its data, so
//   empty stages keep filling while the output waits; nothing is dropped or repeated.
module lyapunov_safety_stop_check_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [15:0]          cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [15:0]   elevation,
	input  logic signed [15:0]   pitch,
	input  logic signed [15:0]   elevation_rate,
	input  logic signed [15:0]   pitch_rate,
	input  logic [15:0]          sim_time,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 stop,
	output logic [1:0]           outcome,
	output logic [15:0]          stop_time,
	output logic [23:0]          potential_value
);
	import lssc_pkg::*;

	// configuration register
	logic [15:0] max_time_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_time_q <= MAX_TIME_RST;
		end else if (cfg_we) begin
			max_time_q <= cfg_wdata;
		end
	end

	// stage valid bits and per-stage load enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	assign rdy5     = !v_s5 || out_ready;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// stage 1 operand selection for the ten quadratic terms
	logic signed [IN_W-1:0] op_a [N_TERMS];
	logic signed [IN_W-1:0] op_b [N_TERMS];

	always_comb begin
		op_a[0] = elevation;      op_b[0] = elevation;
		op_a[1] = pitch;          op_b[1] = pitch;
		op_a[2] = elevation_rate; op_b[2] = elevation_rate;
		op_a[3] = pitch_rate;     op_b[3] = pitch_rate;
		op_a[4] = elevation;      op_b[4] = pitch;
		op_a[5] = elevation;      op_b[5] = elevation_rate;
		op_a[6] = elevation;      op_b[6] = pitch_rate;
		op_a[7] = pitch;          op_b[7] = elevation_rate;
		op_a[8] = pitch;          op_b[8] = pitch_rate;
		op_a[9] = elevation_rate; op_b[9] = pitch_rate;
	end

	// stage 1 envelope and timeout checks
	logic signed [ENV_A_W-1:0] e_x, p_x, e5, a_neg, a_pos;
	logic signed [ENV_B_W-1:0] a_neg10, a_pos10;
	logic                      fail_in;

	always_comb begin
		e_x     = ENV_A_W'(elevation);
		p_x     = ENV_A_W'(pitch);
		e5      = (e_x <<< 2) + e_x;
		a_neg   = -((e_x <<< 1) + e_x) - p_x;
		a_pos   = -((e_x <<< 1) + e_x) + p_x;
		a_neg10 = (ENV_B_W'(a_neg) <<< 3) + (ENV_B_W'(a_neg) <<< 1);
		a_pos10 = (ENV_B_W'(a_pos) <<< 3) + (ENV_B_W'(a_pos) <<< 1);
		fail_in = (sim_time >= max_time_q) || (e5 < ENV_LOW)
			|| (a_neg10 >= ENV_HIGH) || (a_pos10 >= ENV_HIGH);
	end

	// pipeline registers
	logic signed [PROD_W-1:0] prod_s1 [N_TERMS];
	logic signed [TERM_W-1:0] term_s2 [N_TERMS];
	logic signed [ACC_W-1:0]  psum_s3 [3];
	logic signed [ACC_W-1:0]  acc_s4;
	logic                     fail_s1, fail_s2, fail_s3, fail_s4;
	logic [15:0]              t_s1, t_s2, t_s3, t_s4;

	// stage 1: input products
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			for (int i = 0; i < N_TERMS; i++) begin
				prod_s1[i] <= op_a[i] * op_b[i];
			end
			fail_s1 <= fail_in;
			t_s1    <= sim_time;
		end
	end

	// stage 2: weight each product
	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			for (int i = 0; i < N_TERMS; i++) begin
				term_s2[i] <= prod_s1[i] * COEF[i];
			end
			fail_s2 <= fail_s1;
			t_s2    <= t_s1;
		end
	end

	// stage 3: three partial sums
	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			psum_s3[0] <= ACC_W'(term_s2[0]) + ACC_W'(term_s2[1])
				+ ACC_W'(term_s2[2]) + ACC_W'(term_s2[3]);
			psum_s3[1] <= ACC_W'(term_s2[4]) + ACC_W'(term_s2[5]) + ACC_W'(term_s2[6]);
			psum_s3[2] <= ACC_W'(term_s2[7]) + ACC_W'(term_s2[8]) + ACC_W'(term_s2[9]);
			fail_s3    <= fail_s2;
			t_s3       <= t_s2;
		end
	end

	// stage 4: full potential in accumulator format
	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			acc_s4  <= psum_s3[0] + psum_s3[1] + psum_s3[2];
			fail_s4 <= fail_s3;
			t_s4    <= t_s3;
		end
	end

	// stage 5 logic: round to q8.16, classify, saturate
	logic [ACC_W-1:0] rnd;
	logic [POT_W-1:0] pot;
	logic             stable;
	logic [1:0]       outcome_d;

	always_comb begin
		rnd    = $unsigned(acc_s4) + ROUND_HALF;
		pot    = (acc_s4 > 0) ? rnd[ACC_W-1:ROUND_SH] : '0;
		stable = (pot[POT_W-1:16] == '0);
		if (fail_s4) begin
			outcome_d = OUTCOME_FAIL;
		end else if (stable) begin
			outcome_d = OUTCOME_STABLE;
		end else begin
			outcome_d = OUTCOME_CONT;
		end
	end

	// stage 5: output register
	logic                 stop_s5;
	logic [1:0]           outcome_s5;
	logic [15:0]          stop_time_s5;
	logic [POT_OUT_W-1:0] pot_s5;

	always_ff @(posedge clk) begin
		if (rdy5 && v_s4) begin
			stop_s5      <= (outcome_d != OUTCOME_CONT);
			outcome_s5   <= outcome_d;
			stop_time_s5 <= (outcome_d == OUTCOME_STABLE) ? t_s4 : 16'd0;
			pot_s5       <= (pot[POT_W-1:POT_OUT_W] != '0) ? '1 : pot[POT_OUT_W-1:0];
		end
	end

	assign out_valid       = v_s5;
	assign stop            = stop_s5;
	assign outcome         = outcome_s5;
	assign stop_time       = stop_time_s5;
	assign potential_value = pot_s5;

	// checks
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted transaction did not enter stage 1");

	a_stop_matches_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (stop == (outcome != OUTCOME_CONT)))
		else $error("stop disagrees with outcome");

	a_stop_time_only_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (outcome != OUTCOME_STABLE) |-> (stop_time == 16'd0))
		else $error("stop_time set without stable outcome");

	a_stable_below_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (outcome == OUTCOME_STABLE) |-> (potential_value < 24'h010000))
		else $error("stable outcome with potential at or above one");

endmodule

// File: tb/tb_top.sv
// tb_top: self-checking testbench for lyapunov_safety_stop_check_core
// queue-fed driver, checking monitor and a predictor of the quadratic potential and stop decision
// depends on lssc_pkg and the core
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// quadratic form weights, real coefficients times 2^20 rounded to nearest
	localparam int     WEIGHT_FRAC = 20;
	localparam longint W_EE   = 64'sd26700557;
	localparam longint W_PP   = 64'sd3075705;
	localparam longint W_DEDE = 64'sd6043428;
	localparam longint W_DPDP = 64'sd212361;
	localparam longint W_EP   = -64'sd120165;
	localparam longint W_EDE  = 64'sd4497483;
	localparam longint W_EDP  = -64'sd21196;
	localparam longint W_PDE  = -64'sd115418;
	localparam longint W_PDP  = 64'sd275684;
	localparam longint W_DEDP = -64'sd2326;
	localparam int     POT_SHIFT = 2 * lssc_pkg::FRAC_BITS + WEIGHT_FRAC - 16;

	localparam int STALL_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_ITEMS = 180;
	localparam int N_PHASES     = 6;

	typedef struct packed {
		logic [15:0] elevation;
		logic [15:0] pitch;
		logic [15:0] elevation_rate;
		logic [15:0] pitch_rate;
		logic [15:0] sim_time;
	} plant_state_t;

	typedef struct packed {
		logic        stop;
		logic [1:0]  outcome;
		logic [15:0] stop_time;
		logic [23:0] potential_value;
	} stop_verdict_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [15:0] elevation = '0;
	logic [15:0] pitch = '0;
	logic [15:0] elevation_rate = '0;
	logic [15:0] pitch_rate = '0;
	logic [15:0] sim_time = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        stop;
	logic [1:0]  outcome;
	logic [15:0] stop_time;
	logic [23:0] potential_value;

	plant_state_t  pending_states[$];
	stop_verdict_t expected_verdicts[$];
	logic [15:0]   time_limit = lssc_pkg::MAX_TIME_RST;
	int            send_idle_pct = 13;
	int            recv_idle_pct = 13;
	int            mismatches = 0;

	lyapunov_safety_stop_check_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.elevation       (elevation),
		.pitch           (pitch),
		.elevation_rate  (elevation_rate),
		.pitch_rate      (pitch_rate),
		.sim_time        (sim_time),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.stop            (stop),
		.outcome         (outcome),
		.stop_time       (stop_time),
		.potential_value (potential_value)
	);

	always #5 clk = ~clk;

	// potential x'Px, envelope and timeout classification for one plant state
	function automatic stop_verdict_t predict_verdict(plant_state_t s, logic [15:0] limit);
		longint e, p, de, dp, acc, pot, one;
		bit fail, stable;
		stop_verdict_t v;
		e  = longint'($signed(s.elevation));
		p  = longint'($signed(s.pitch));
		de = longint'($signed(s.elevation_rate));
		dp = longint'($signed(s.pitch_rate));
		acc = W_EE * e * e + W_PP * p * p + W_DEDE * de * de + W_DPDP * dp * dp
			+ 2 * W_EP * e * p + 2 * W_EDE * e * de + 2 * W_EDP * e * dp
			+ 2 * W_PDE * p * de + 2 * W_PDP * p * dp + 2 * W_DEDP * de * dp;
		// round to q8.16, ties upward; a negative sum reads as zero
		pot = 0;
		if (acc > 0)
			pot = (acc + (longint'(1) << (POT_SHIFT - 1))) >>> POT_SHIFT;
		stable = pot < (longint'(1) << 16);
		one = longint'(1) << lssc_pkg::FRAC_BITS;
		fail = (s.sim_time >= limit) || (5 * e < -2 * one)
			|| (10 * (-3 * e - p) >= 9 * one) || (10 * (-3 * e + p) >= 9 * one);
		if (fail)
			v.outcome = lssc_pkg::OUTCOME_FAIL;
		else if (stable)
			v.outcome = lssc_pkg::OUTCOME_STABLE;
		else
			v.outcome = lssc_pkg::OUTCOME_CONT;
		v.stop = (v.outcome != lssc_pkg::OUTCOME_CONT);
		v.stop_time = (v.outcome == lssc_pkg::OUTCOME_STABLE) ? s.sim_time : 16'd0;
		v.potential_value = (pot > 64'sd16777215) ? 24'hFFFFFF : pot[23:0];
		return v;
	endfunction

	function automatic int spread(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// random plant state: full range, near the stable set, near the envelope edges, or a mix
	function automatic plant_state_t random_state(logic [15:0] limit);
		plant_state_t s;
		int e, p, de, dp, t;
		e  = int'($signed(16'($urandom())));
		p  = int'($signed(16'($urandom())));
		de = int'($signed(16'($urandom())));
		dp = int'($signed(16'($urandom())));
		case ($urandom_range(0, 3))
			0: ;
			1: begin
				e = spread(900); p = spread(2500); de = spread(1800); dp = spread(9000);
			end
			2: begin
				if ($urandom_range(0, 1)) begin
					e = -1638 + spread(3);
					p = spread(300);
				end else begin
					e = spread(400);
					p = $urandom_range(0, 1) ? (-3 * e - 3687 + spread(3))
						: (3 * e + 3687 + spread(3));
				end
				de = spread(1000); dp = spread(4000);
			end
			default: begin
				if ($urandom_range(0, 1)) e = spread(900);
				if ($urandom_range(0, 1)) p = spread(2500);
				if ($urandom_range(0, 1)) de = spread(1800);
				if ($urandom_range(0, 1)) dp = spread(9000);
			end
		endcase
		case ($urandom_range(0, 3))
			0, 1: t = int'($urandom_range(0, limit));
			2: t = int'($urandom_range(0, 65535));
			default: begin
				t = int'(limit) + spread(2);
				if (t < 0) t = 0;
				if (t > 65535) t = 65535;
			end
		endcase
		s.elevation = 16'(e);
		s.pitch = 16'(p);
		s.elevation_rate = 16'(de);
		s.pitch_rate = 16'(dp);
		s.sim_time = 16'(t);
		return s;
	endfunction

	task automatic queue_state(int e, int p, int de, int dp, int t);
		plant_state_t s;
		s.elevation = 16'(e);
		s.pitch = 16'(p);
		s.elevation_rate = 16'(de);
		s.pitch_rate = 16'(dp);
		s.sim_time = 16'(t);
		pending_states.push_back(s);
	endtask

	// wait until nothing is queued, offered or in flight, sampled away from the edge
	task automatic drain();
		do
			@(negedge clk);
		while (pending_states.size() > 0 || in_valid || expected_verdicts.size() > 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_max_time(logic [15:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		time_limit = value;
	endtask

	// input driver: offers queued states, records the verdict of each accepted transaction
	always @(posedge clk) begin : state_driver
		plant_state_t s;
		bit taken;
		taken = 1'b0;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				s = {elevation, pitch, elevation_rate, pitch_rate, sim_time};
				expected_verdicts.push_back(predict_verdict(s, time_limit));
				taken = 1'b1;
			end
			if (!in_valid || taken) begin
				if (pending_states.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					s = pending_states.pop_front();
					in_valid <= 1'b1;
					elevation <= s.elevation;
					pitch <= s.pitch;
					elevation_rate <= s.elevation_rate;
					pitch_rate <= s.pitch_rate;
					sim_time <= s.sim_time;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor: compares each accepted verdict with the oldest expectation
	int  verdicts_seen = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	always @(posedge clk) begin : verdict_monitor
		stop_verdict_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				verdicts_seen++;
				if (expected_verdicts.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected transaction: stop=%0d outcome=%0d %s",
							stop, outcome,
							$sformatf("stop_time=%0d pot=%0h", stop_time, potential_value));
				end else begin
					want = expected_verdicts.pop_front();
					if (stop !== want.stop || outcome !== want.outcome
						|| stop_time !== want.stop_time
						|| potential_value !== want.potential_value) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch #%0d: exp %s, got %s", verdicts_seen,
								$sformatf("stop=%0d outcome=%0d stop_time=%0d pot=%0h",
									want.stop, want.outcome, want.stop_time,
									want.potential_value),
								$sformatf("stop=%0d outcome=%0d stop_time=%0d pot=%0h",
									stop, outcome, stop_time, potential_value));
					end
				end
			end
			// one long hold-off while the sender still has plenty queued
			if (!hold_done && verdicts_seen >= 200 && pending_states.size() > 100) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// watchdog: cycles with work outstanding but no transaction on either channel
	int stall_cycles = 0;
	always @(posedge clk) begin : watchdog
		if ((in_valid && in_ready) || (out_valid && out_ready)
			|| (pending_states.size() == 0 && expected_verdicts.size() == 0 && !in_valid))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// reset, directed states, then random phases over several time limits
	initial begin : stimulus
		logic [15:0] limit;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, with the reset time limit of 20
		queue_state(0, 0, 0, 0, 0);
		queue_state(0, 0, 0, 0, 19);
		queue_state(0, 0, 0, 0, 20);
		queue_state(0, 0, 0, 0, 65535);
		queue_state(32767, 32767, 32767, 32767, 5);
		queue_state(-32768, -32768, -32768, -32768, 5);
		queue_state(32767, -32768, -32768, -32768, 3);
		queue_state(-32768, 32767, 0, 0, 0);
		// elevation floor at -0.4
		queue_state(-1638, 0, 0, 0, 1);
		queue_state(-1639, 0, 0, 0, 1);
		// pitch side limits of the envelope
		queue_state(0, -3686, 0, 0, 2);
		queue_state(0, -3687, 0, 0, 2);
		queue_state(0, 3686, 0, 0, 2);
		queue_state(0, 3687, 0, 0, 2);
		// potential just under and just over one
		queue_state(811, 0, 0, 0, 7);
		queue_state(812, 0, 0, 0, 7);
		queue_state(0, 0, 1700, 0, 8);
		queue_state(0, 0, 0, 9000, 8);
		queue_state(-1, 1, -1, 1, 4);
		queue_state(1000, -1000, 0, 0, 4);
		queue_state(0, 0, 32767, -32768, 4);
		queue_state(600, -600, -600, 600, 10);
		queue_state(-800, 2400, -1500, 8000, 11);
		drain();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0: limit = 16'd0;
				1: limit = 16'hFFFF;
				2: limit = 16'd1000;
				4: limit = 16'd1;
				default: limit = 16'($urandom());
			endcase
			write_max_time(limit);
			send_idle_pct = (ph == 3) ? 0 : 13;
			recv_idle_pct = (ph == 3) ? 0 : 13;
			for (int i = 0; i < RANDOM_ITEMS; i++)
				pending_states.push_back(random_state(limit));
			drain();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_verdicts.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: lyapunov_safety_stop_check_core.f
design/lssc_pkg.sv
design/lyapunov_safety_stop_check_core.sv
tb/tb_top.sv
